/* rtl/trf_pkg.sv */
`timescale 1ns / 1ps

package trf_pkg;

	// Command codes of an input request
	localparam logic [3:0] CMD_CLEAR     = 4'd0;
	localparam logic [3:0] CMD_TASK_ADD  = 4'd1;
	localparam logic [3:0] CMD_TYPE_ADD  = 4'd2;
	localparam logic [3:0] CMD_STATE     = 4'd3;
	localparam logic [3:0] CMD_EV_HEADER = 4'd4;
	localparam logic [3:0] CMD_EV_PAIR   = 4'd5;
	localparam logic [3:0] CMD_COMM      = 4'd6;
	localparam logic [3:0] CMD_GCOMM     = 4'd7;
	localparam logic [3:0] CMD_OTHER     = 4'd8;

	// State value that marks a running state
	localparam logic [7:0] RUNNING_STATE = 8'd1;

	// Depth of the queue between front and back
	localparam int Q_DEPTH = 2;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_ENABLE_STATES  = 3'd0,
		REG_ENABLE_COMMS   = 3'd1,
		REG_ENABLE_EVENTS  = 3'd2,
		REG_FILTER_BY_TASK = 3'd3,
		REG_PASS_ALL_TYPES = 3'd4,
		REG_MIN_STATE_DUR  = 3'd5,
		REG_MAX_STATE_DUR  = 3'd6,
		REG_MIN_COMM_SIZE  = 3'd7
	} reg_idx_t;

	// Classified request kind
	typedef enum logic [3:0] {
		K_CLEAR,
		K_TASK_ADD,
		K_TYPE_ADD,
		K_STATE,
		K_EV_HEADER,
		K_EV_PAIR,
		K_COMM,
		K_GCOMM,
		K_OTHER
	} kind_t;

	typedef struct packed {
		logic        enable_states;
		logic        enable_comms;
		logic        enable_events;
		logic        filter_by_task;
		logic        pass_all_types;
		logic [63:0] min_state_duration;
		logic [63:0] max_state_duration;
		logic [30:0] min_msg_size;
	} cfg_t;

	// One classified request as it travels from front to back
	typedef struct packed {
		kind_t       kind;
		logic [15:0] task_id;
		logic [15:0] partner_task;
		logic        state_ok;
		logic        size_ok;
		logic [63:0] event_type;
		logic        last_pair;
		logic [63:0] rule_low;
		logic [63:0] rule_high;
	} op_t;

endpackage

/* rtl/trace_record_filter_unit.sv */
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// ------    ---------             -------
// in        in_valid / in_stall   command, task_id, partner_task, begin_time, end_time,
//                                 state_code, comm_size, event_type, event_value,
//                                 last_pair, rule_low, rule_high
// out       out_valid / out_stall keep_record, keep_pair, record_done, kept_count,
//                                 table_full
// cfg       cfg_write             cfg_index, cfg_data
//
// Every request gives exactly one result. The back end takes each request through
// rule match, then decide, and takes the next one only as it finishes decide.
// A request passes the front stage, the queue, match, decide and the result register.
// Reset clears rule counts, the open event and the kept counter; rule tables are
// not cleared and are read only below their counts. A two-entry queue separates
// classification from execution, so an output stall backs up into in_stall only
// once the queue and the front stage are full.

module trace_record_filter_unit #(
	parameter int TASK_RULES = 32,
	parameter int TYPE_RULES = 32,
	parameter int TASK_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  command,
	input  logic [15:0] task_id,
	input  logic [15:0] partner_task,
	input  logic [63:0] begin_time,
	input  logic [63:0] end_time,
	input  logic [7:0]  state_code,
	input  logic [30:0] comm_size,
	input  logic [63:0] event_type,
	input  logic [63:0] event_value,
	input  logic        last_pair,
	input  logic [63:0] rule_low,
	input  logic [63:0] rule_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        keep_record,
	output logic        keep_pair,
	output logic        record_done,
	output logic [63:0] kept_count,
	output logic        table_full
);

	trf_pkg::cfg_t cfg_q;
	logic          push_valid;
	logic          push_stall;
	trf_pkg::op_t  push_op;
	logic          pop_valid;
	logic          pop;
	trf_pkg::op_t  pop_op;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				trf_pkg::REG_ENABLE_STATES:  cfg_q.enable_states      <= cfg_data[0];
				trf_pkg::REG_ENABLE_COMMS:   cfg_q.enable_comms       <= cfg_data[0];
				trf_pkg::REG_ENABLE_EVENTS:  cfg_q.enable_events      <= cfg_data[0];
				trf_pkg::REG_FILTER_BY_TASK: cfg_q.filter_by_task     <= cfg_data[0];
				trf_pkg::REG_PASS_ALL_TYPES: cfg_q.pass_all_types     <= cfg_data[0];
				trf_pkg::REG_MIN_STATE_DUR:  cfg_q.min_state_duration <= cfg_data;
				trf_pkg::REG_MAX_STATE_DUR:  cfg_q.max_state_duration <= cfg_data;
				trf_pkg::REG_MIN_COMM_SIZE:  cfg_q.min_msg_size       <= cfg_data[30:0];
				default:                     cfg_q                    <= cfg_q;
			endcase
		end
	end

	trf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.task_id      (task_id),
		.partner_task (partner_task),
		.begin_time   (begin_time),
		.end_time     (end_time),
		.state_code   (state_code),
		.comm_size    (comm_size),
		.event_type   (event_type),
		.last_pair    (last_pair),
		.rule_low     (rule_low),
		.rule_high    (rule_high),
		.push_valid   (push_valid),
		.push_stall   (push_stall),
		.push_op      (push_op)
	);

	trf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_op     (pop_op)
	);

	trf_back #(
		.TASK_RULES (TASK_RULES),
		.TYPE_RULES (TYPE_RULES),
		.TASK_BITS  (TASK_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pop_valid   (pop_valid),
		.pop         (pop),
		.pop_op      (pop_op),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.keep_record (keep_record),
		.keep_pair   (keep_pair),
		.record_done (record_done),
		.kept_count  (kept_count),
		.table_full  (table_full)
	);

endmodule

/* rtl/trf_front.sv */
`timescale 1ns / 1ps

module trf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  trf_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [3:0]        command,
	input  logic [15:0]       task_id,
	input  logic [15:0]       partner_task,
	input  logic [63:0]       begin_time,
	input  logic [63:0]       end_time,
	input  logic [7:0]        state_code,
	input  logic [30:0]       comm_size,
	input  logic [63:0]       event_type,
	input  logic              last_pair,
	input  logic [63:0]       rule_low,
	input  logic [63:0]       rule_high,
	output logic              push_valid,
	input  logic              push_stall,
	output trf_pkg::op_t      push_op
);

	logic            valid_s1;
	trf_pkg::op_t    op_s1;
	trf_pkg::op_t    op_d;
	trf_pkg::kind_t  kind;
	logic [63:0]     duration;
	logic            accept;

	// Hold the request while the queue is full
	assign in_stall   = valid_s1 & push_stall;
	assign accept     = in_valid & ~in_stall;
	assign push_valid = valid_s1;
	assign push_op    = op_s1;

	// Decode the command
	always_comb begin
		unique case (command)
			trf_pkg::CMD_CLEAR:     kind = trf_pkg::K_CLEAR;
			trf_pkg::CMD_TASK_ADD:  kind = trf_pkg::K_TASK_ADD;
			trf_pkg::CMD_TYPE_ADD:  kind = trf_pkg::K_TYPE_ADD;
			trf_pkg::CMD_STATE:     kind = trf_pkg::K_STATE;
			trf_pkg::CMD_EV_HEADER: kind = trf_pkg::K_EV_HEADER;
			trf_pkg::CMD_EV_PAIR:   kind = trf_pkg::K_EV_PAIR;
			trf_pkg::CMD_COMM:      kind = trf_pkg::K_COMM;
			trf_pkg::CMD_GCOMM:     kind = trf_pkg::K_GCOMM;
			default:                kind = trf_pkg::K_OTHER;
		endcase
	end

	// Classify: state duration and running check, message size check
	always_comb begin
		duration          = end_time - begin_time;
		op_d.kind         = kind;
		op_d.task_id      = task_id;
		op_d.partner_task = partner_task;
		op_d.state_ok     = (state_code == trf_pkg::RUNNING_STATE)
			&& (duration >= cfg.min_state_duration)
			&& ((cfg.max_state_duration == 64'd0) || (duration <= cfg.max_state_duration));
		op_d.size_ok      = (comm_size >= cfg.min_msg_size);
		op_d.event_type   = event_type;
		op_d.last_pair    = last_pair;
		op_d.rule_low     = rule_low;
		op_d.rule_high    = rule_high;
	end

	// Stage valid: set on accept, drop once pushed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!push_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_d;
		end
	end

endmodule

/* rtl/trf_queue.sv */
`timescale 1ns / 1ps

module trf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_stall,
	input  trf_pkg::op_t  push_op,
	output logic          pop_valid,
	input  logic          pop,
	output trf_pkg::op_t  pop_op
);

	localparam int PW = (trf_pkg::Q_DEPTH > 1) ? $clog2(trf_pkg::Q_DEPTH) : 1;
	localparam int CW = $clog2(trf_pkg::Q_DEPTH + 1);

	trf_pkg::op_t  mem_q [trf_pkg::Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_stall = (count_q == CW'(trf_pkg::Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = mem_q[rd_ptr_q];
	assign do_push    = push_valid & ~push_stall;
	assign do_pop     = pop & pop_valid;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(trf_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(trf_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

/* rtl/trf_back.sv */
`timescale 1ns / 1ps

module trf_back #(
	parameter int TASK_RULES = 32,
	parameter int TYPE_RULES = 32,
	parameter int TASK_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  trf_pkg::cfg_t cfg,
	input  logic          pop_valid,
	output logic          pop,
	input  trf_pkg::op_t  pop_op,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          keep_record,
	output logic          keep_pair,
	output logic          record_done,
	output logic [63:0]   kept_count,
	output logic          table_full
);

	localparam int TK_IW = (TASK_RULES > 1) ? $clog2(TASK_RULES) : 1;
	localparam int TY_IW = (TYPE_RULES > 1) ? $clog2(TYPE_RULES) : 1;
	localparam int TK_CW = $clog2(TASK_RULES + 1);
	localparam int TY_CW = $clog2(TYPE_RULES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_DECIDE
	} state_t;

	state_t                state_q;
	trf_pkg::op_t          op_q;

	// Rule tables
	logic [TASK_BITS-1:0]  task_lo_q [TASK_RULES];
	logic [TASK_BITS-1:0]  task_hi_q [TASK_RULES];
	logic [63:0]           type_lo_q [TYPE_RULES];
	logic [63:0]           type_hi_q [TYPE_RULES];
	logic [TK_CW-1:0]      task_cnt_q;
	logic [TY_CW-1:0]      type_cnt_q;

	// Open event record
	logic                  ev_open_q;
	logic                  ev_sel_q;
	logic                  ev_any_q;
	logic [63:0]           kept_q;

	// Per-entry rule hits
	logic [TASK_RULES-1:0] task_hit_q;
	logic [TASK_RULES-1:0] part_hit_q;
	logic [TYPE_RULES-1:0] type_hit_q;
	logic [TASK_RULES-1:0] task_hit_d;
	logic [TASK_RULES-1:0] part_hit_d;
	logic [TYPE_RULES-1:0] type_hit_d;

	logic [TASK_BITS+15:0] task_wide;
	logic [TASK_BITS+15:0] part_wide;
	logic [TASK_BITS-1:0]  task_m;
	logic [TASK_BITS-1:0]  part_m;

	logic                  out_free;
	logic                  finish;
	logic                  task_ok;
	logic                  part_ok;
	logic                  type_sel;
	logic                  keep_rec_d;
	logic                  keep_pr_d;
	logic                  done_d;
	logic                  full_d;
	logic                  count_d;
	logic                  task_add;
	logic                  type_add;

	assign out_free = ~out_valid | ~out_stall;
	assign finish   = (state_q == S_DECIDE) && out_free;
	assign pop      = pop_valid && ((state_q == S_IDLE) || finish);
	assign task_add = finish && (op_q.kind == trf_pkg::K_TASK_ADD)
		&& (task_cnt_q != TK_CW'(TASK_RULES));
	assign type_add = finish && (op_q.kind == trf_pkg::K_TYPE_ADD)
		&& (type_cnt_q != TY_CW'(TYPE_RULES));

	// Compare the request against every live rule
	always_comb begin
		task_wide = {{TASK_BITS{1'b0}}, op_q.task_id};
		part_wide = {{TASK_BITS{1'b0}}, op_q.partner_task};
		task_m    = task_wide[TASK_BITS-1:0];
		part_m    = part_wide[TASK_BITS-1:0];
		for (int i = 0; i < TASK_RULES; i++) begin
			task_hit_d[i] = (TK_CW'(i) < task_cnt_q)
				&& (task_m >= task_lo_q[i]) && (task_m <= task_hi_q[i]);
			part_hit_d[i] = (TK_CW'(i) < task_cnt_q)
				&& (part_m >= task_lo_q[i]) && (part_m <= task_hi_q[i]);
		end
		for (int j = 0; j < TYPE_RULES; j++) begin
			type_hit_d[j] = (TY_CW'(j) < type_cnt_q)
				&& (op_q.event_type >= type_lo_q[j]) && (op_q.event_type <= type_hi_q[j]);
		end
	end

	// Decide the result of the request
	always_comb begin
		task_ok    = ~cfg.filter_by_task | (|task_hit_q);
		part_ok    = ~cfg.filter_by_task | (|part_hit_q);
		type_sel   = |type_hit_q;
		keep_rec_d = 1'b0;
		keep_pr_d  = 1'b0;
		done_d     = 1'b0;
		full_d     = 1'b0;
		count_d    = 1'b0;
		case (op_q.kind) inside
			trf_pkg::K_TASK_ADD: begin
				full_d = (task_cnt_q == TK_CW'(TASK_RULES));
			end
			trf_pkg::K_TYPE_ADD: begin
				full_d = (type_cnt_q == TY_CW'(TYPE_RULES));
			end
			trf_pkg::K_STATE: begin
				done_d     = 1'b1;
				keep_rec_d = cfg.enable_states & task_ok & op_q.state_ok;
				count_d    = keep_rec_d;
			end
			trf_pkg::K_EV_PAIR: begin
				if (ev_open_q) begin
					keep_pr_d = ev_sel_q & (cfg.pass_all_types | type_sel);
					if (op_q.last_pair) begin
						done_d     = 1'b1;
						keep_rec_d = ev_sel_q & (cfg.pass_all_types | ev_any_q | keep_pr_d);
						count_d    = keep_rec_d;
					end
				end
			end
			trf_pkg::K_COMM: begin
				done_d     = 1'b1;
				keep_rec_d = cfg.enable_comms & task_ok & part_ok & op_q.size_ok;
				count_d    = keep_rec_d;
			end
			trf_pkg::K_GCOMM: begin
				done_d     = 1'b1;
				keep_rec_d = 1'b1;
			end
			trf_pkg::K_CLEAR, trf_pkg::K_EV_HEADER: begin
				done_d = 1'b0;
			end
			default: begin
				done_d = 1'b1;
			end
		endcase
	end

	// Sequence each request through match and decide; hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			task_cnt_q  <= '0;
			type_cnt_q  <= '0;
			ev_open_q   <= 1'b0;
			ev_sel_q    <= 1'b0;
			ev_any_q    <= 1'b0;
			kept_q      <= '0;
			out_valid   <= 1'b0;
			keep_record <= 1'b0;
			keep_pair   <= 1'b0;
			record_done <= 1'b0;
			kept_count  <= '0;
			table_full  <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (finish) begin
						state_q     <= pop ? S_MATCH : S_IDLE;
						out_valid   <= 1'b1;
						keep_record <= keep_rec_d;
						keep_pair   <= keep_pr_d;
						record_done <= done_d;
						table_full  <= full_d;
						kept_count  <= count_d ? kept_q + 64'd1 : kept_q;
						if (count_d) begin
							kept_q <= kept_q + 64'd1;
						end
						if (op_q.kind != trf_pkg::K_EV_PAIR) begin
							ev_open_q <= 1'b0;
						end
						case (op_q.kind)
							trf_pkg::K_CLEAR: begin
								task_cnt_q <= '0;
								type_cnt_q <= '0;
							end
							trf_pkg::K_TASK_ADD: begin
								if (task_add) begin
									task_cnt_q <= task_cnt_q + TK_CW'(1);
								end
							end
							trf_pkg::K_TYPE_ADD: begin
								if (type_add) begin
									type_cnt_q <= type_cnt_q + TY_CW'(1);
								end
							end
							trf_pkg::K_EV_HEADER: begin
								ev_open_q <= 1'b1;
								ev_sel_q  <= cfg.enable_events & task_ok;
								ev_any_q  <= 1'b0;
							end
							trf_pkg::K_EV_PAIR: begin
								if (ev_open_q) begin
									if (keep_pr_d) begin
										ev_any_q <= 1'b1;
									end
									if (op_q.last_pair) begin
										ev_open_q <= 1'b0;
									end
								end
							end
							default: begin
								ev_any_q <= ev_any_q;
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Load the request and its rule hits
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= pop_op;
		end
		if (state_q == S_MATCH) begin
			task_hit_q <= task_hit_d;
			part_hit_q <= part_hit_d;
			type_hit_q <= type_hit_d;
		end
	end

	// Write added rules at the next free slot
	always_ff @(posedge clk) begin
		if (task_add) begin
			task_lo_q[task_cnt_q[TK_IW-1:0]] <= op_q.rule_low[TASK_BITS-1:0];
			task_hi_q[task_cnt_q[TK_IW-1:0]] <= op_q.rule_high[TASK_BITS-1:0];
		end
		if (type_add) begin
			type_lo_q[type_cnt_q[TY_IW-1:0]] <= op_q.rule_low;
			type_hi_q[type_cnt_q[TY_IW-1:0]] <= op_q.rule_high;
		end
	end

endmodule
